@@ sv/rapq_pkg.sv @@
package rapq_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int ADDR_W      = IDX_W + 1;
   localparam int NODE_W      = IDX_W + 2;
   localparam int VAL_W       = 64;
   localparam int AMT_W       = 32;
   localparam int OP_W        = 2;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [IDX_W-1:0]        first_index;
      logic [IDX_W-1:0]        last_index;
      logic signed [AMT_W-1:0] amount;
      logic signed [VAL_W-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    out_of_range;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_CHK,
      ST_ADD_WR,
      ST_WALK,
      ST_WALK_END,
      ST_LOAD_WR,
      ST_FIN
   } state_type;

endpackage

@@ sv/range_add_point_query_tree.sv @@
// Range-add / point-query tree over up to 1024 signed 64-bit entries.
// req channel: one beat per item (load, range add, query), valid/stall.
// rsp channel: one beat per query, valid/stall; loads and adds give none.
// csr channel: valid/ready write of entries_in_use (saturates at 1024);
//   taken only while the block is idle.
// All state sits in one 2048 x 64 node memory (implicit binary tree, leaf
// nodes at 1024 + index) with a registered read; each node update is a
// read then a write-back.
// Query: walks leaf to root, 11 reads pipelined. Load: 10 reads then one
//   write.
// Range add: up to two node updates per tree level over 10 levels. One
//   item is in flight at a time; req_stall is high until it finishes.
// Reset: a clearing pass writes zero to all 2048 nodes, one per cycle;
//   req_stall and !csr_ready hold through it.
// A query result waits in the output register while rsp_stall is high; the
//   next query's walk runs meanwhile and holds at its end until the
//   register frees.
module range_add_point_query_tree (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  rapq_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rapq_pkg::rsp_type        rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [rapq_pkg::CNT_W-1:0] csr_data
);

   localparam logic [rapq_pkg::NODE_W-1:0] LEAF_BASE =
      rapq_pkg::NODE_W'(rapq_pkg::MAX_ENTRIES);
   localparam logic [rapq_pkg::CNT_W-1:0] MAX_CNT =
      rapq_pkg::CNT_W'(rapq_pkg::MAX_ENTRIES);

   logic [rapq_pkg::VAL_W-1:0] mem [2**rapq_pkg::ADDR_W];

   rapq_pkg::state_type state_ff, state_in;
   logic [rapq_pkg::NODE_W-1:0]  node_l_ff, node_r_ff;
   logic [rapq_pkg::ADDR_W-1:0]  tgt_ff, clr_ff;
   logic [rapq_pkg::VAL_W-1:0]   sum_ff, rdata_ff;
   logic                         acc_ff, oor_ff;
   rapq_pkg::req_type            item_ff;
   rapq_pkg::rsp_type            rsp_ff;
   logic                         rsp_valid_ff;
   logic [rapq_pkg::CNT_W-1:0]   entries_ff;

   logic                         accept, out_free, in_range, add_ok;
   logic [rapq_pkg::ADDR_W-1:0]  raddr, waddr;
   logic [rapq_pkg::VAL_W-1:0]   wdata;
   logic                         we;
   logic [rapq_pkg::VAL_W-1:0]   amt_ext;

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_range  = {1'b0, req_data.first_index} < entries_ff;
   assign add_ok    = in_range && ({1'b0, req_data.last_index} < entries_ff)
                      && (req_data.first_index <= req_data.last_index);
   assign amt_ext   = rapq_pkg::VAL_W'(item_ff.amount);
   assign req_stall = (state_ff != rapq_pkg::ST_IDLE);
   assign csr_ready = (state_ff == rapq_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rapq_pkg::ST_CLEAR: begin
            if (&clr_ff) state_in = rapq_pkg::ST_IDLE;
         end
         rapq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  rapq_pkg::OP_LOAD:  if (in_range) state_in = rapq_pkg::ST_WALK;
                  rapq_pkg::OP_ADD:   if (add_ok) state_in = rapq_pkg::ST_ADD_CHK;
                  rapq_pkg::OP_QUERY: state_in = in_range ? rapq_pkg::ST_WALK
                                                          : rapq_pkg::ST_FIN;
                  default:            state_in = rapq_pkg::ST_IDLE;
               endcase
            end
         end
         rapq_pkg::ST_ADD_CHK: begin
            if (node_l_ff >= node_r_ff) state_in = rapq_pkg::ST_IDLE;
            else if (node_l_ff[0] || node_r_ff[0]) state_in = rapq_pkg::ST_ADD_WR;
         end
         rapq_pkg::ST_ADD_WR:  state_in = rapq_pkg::ST_ADD_CHK;
         rapq_pkg::ST_WALK: begin
            if (node_l_ff == rapq_pkg::NODE_W'(1)) state_in = rapq_pkg::ST_WALK_END;
         end
         rapq_pkg::ST_WALK_END: begin
            state_in = (item_ff.op == rapq_pkg::OP_LOAD) ? rapq_pkg::ST_LOAD_WR
                                                          : rapq_pkg::ST_FIN;
         end
         rapq_pkg::ST_LOAD_WR: state_in = rapq_pkg::ST_IDLE;
         rapq_pkg::ST_FIN: begin
            if (out_free) state_in = rapq_pkg::ST_IDLE;
         end
         default: state_in = rapq_pkg::ST_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      raddr = node_l_ff[rapq_pkg::ADDR_W-1:0];
      we    = 1'b0;
      waddr = tgt_ff;
      wdata = rdata_ff + amt_ext;
      case (state_ff)
         rapq_pkg::ST_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            wdata = '0;
         end
         rapq_pkg::ST_ADD_CHK: begin
            if (!node_l_ff[0]) begin
               raddr = rapq_pkg::ADDR_W'(node_r_ff - rapq_pkg::NODE_W'(1));
            end
         end
         rapq_pkg::ST_ADD_WR: we = 1'b1;
         rapq_pkg::ST_LOAD_WR: begin
            we    = 1'b1;
            wdata = item_ff.load_value - sum_ff;
         end
         default: we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rapq_pkg::ST_CLEAR;
         clr_ff       <= '0;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         entries_ff   <= MAX_CNT;
      end else begin
         state_ff <= state_in;
         acc_ff   <= (state_ff == rapq_pkg::ST_WALK);
         if (state_ff == rapq_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_valid && csr_ready) begin
            entries_ff <= (csr_data > MAX_CNT) ? MAX_CNT : csr_data;
         end
         if (state_ff == rapq_pkg::ST_FIN && out_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (acc_ff) sum_ff <= sum_ff + rdata_ff;
      case (state_ff)
         rapq_pkg::ST_IDLE: begin
            if (accept) begin
               item_ff <= req_data;
               sum_ff  <= '0;
               oor_ff  <= !in_range;
               tgt_ff  <= rapq_pkg::ADDR_W'(LEAF_BASE + rapq_pkg::NODE_W'(req_data.first_index));
               if (req_data.op == rapq_pkg::OP_LOAD) begin
                  // leaf itself is rewritten, walk starts at its parent
                  node_l_ff <= (LEAF_BASE + rapq_pkg::NODE_W'(req_data.first_index)) >> 1;
               end else begin
                  node_l_ff <= LEAF_BASE + rapq_pkg::NODE_W'(req_data.first_index);
               end
               node_r_ff <= LEAF_BASE + rapq_pkg::NODE_W'(req_data.last_index)
                            + rapq_pkg::NODE_W'(1);
            end
         end
         rapq_pkg::ST_ADD_CHK: begin
            if (node_l_ff < node_r_ff) begin
               if (node_l_ff[0]) begin
                  tgt_ff    <= node_l_ff[rapq_pkg::ADDR_W-1:0];
                  node_l_ff <= node_l_ff + rapq_pkg::NODE_W'(1);
               end else if (node_r_ff[0]) begin
                  tgt_ff    <= rapq_pkg::ADDR_W'(node_r_ff - rapq_pkg::NODE_W'(1));
                  node_r_ff <= node_r_ff - rapq_pkg::NODE_W'(1);
               end else begin
                  node_l_ff <= node_l_ff >> 1;
                  node_r_ff <= node_r_ff >> 1;
               end
            end
         end
         rapq_pkg::ST_WALK: node_l_ff <= node_l_ff >> 1;
         rapq_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_ff.value        <= oor_ff ? '0 : sum_ff;
               rsp_ff.out_of_range <= oor_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

@@ sv/rapq_checker.sv @@
module rapq_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input rapq_pkg::rsp_type        rsp_data,
   input logic                     csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |-> rsp_data.value == '0)
      else $error("out of range result with nonzero value");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall && !csr_ready)
      else $error("block open right after reset");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready != req_stall)
      else $error("csr port open while an item is in flight");

endmodule

bind range_add_point_query_tree rapq_checker u_rapq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
